// ----- src/hsa_pkg.sv -----
package hsa_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
    logic                     is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     is_final;
    logic                     overflowed;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UPC,
    S_XRD,
    S_XSWP,
    S_SD,
    S_ORD,
    S_OLD
  } hsa_state_e;

endpackage

// ----- src/hsa_ram.sv -----
module hsa_ram import hsa_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr0_i,
  input  logic [AW-1:0]            raddr1_i,
  output logic signed [DATA_W-1:0] rdata0_o,
  output logic signed [DATA_W-1:0] rdata1_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // out-of-range read addresses only occur for children that are masked off
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

// ----- src/heap_sort_ascending_core.sv -----
// Heap sorter: signed 32-bit values enter one beat at a time and are inserted
// into a max-heap held in a two-read, one-write RAM of CAPACITY entries. An
// insert climbs from the new leaf, comparing against one parent at a time in
// a read-compare-write loop on the RAM. On the beat marked is_last the block
// sorts in place: each of the n-1 extractions reads the root and the last
// entry, then moves the hole down level by level, both children being read
// together. Then the n values leave in ascending order, each one read from
// the RAM and held until the output is free; is_final marks the last one and
// overflowed is set on every beat of a run in which values beyond CAPACITY
// were dropped. Input is stalled while a beat is inserted, and from the
// is_last beat until the last sorted value sits in the output register.
module heap_sort_ascending_core import hsa_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = AW + 2;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  hsa_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] hk_q, hk_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic ovf_q, ovf_d;
  logic last_q, last_d;
  logic signed [DATA_W-1:0] carry_q, carry_d;
  out_beat_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic we, re;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic signed [DATA_W-1:0] wdata, rdata0, rdata1;

  hsa_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  logic [AW-1:0] parent;
  logic [PW-1:0] lchild, rchild, nl, nr;
  logic l_ok, r_ok, out_free, is_final;
  logic [1:0] bsel;
  logic signed [DATA_W-1:0] bigv;
  logic [AW-1:0] npos;

  always_comb begin
    parent   = (pos_q - AW'(1)) >> 1;
    lchild   = {1'b0, pos_q, 1'b1};
    rchild   = {1'b0, pos_q, 1'b0} + PW'(2);
    l_ok     = lchild < PW'(hk_q);
    r_ok     = rchild < PW'(hk_q);
    out_free = !out_valid_q || !out_stall_i;
    is_final = (CW'(idx_q) + CW'(1)) == count_q;

    bigv = carry_q;
    bsel = 2'd0;
    if (l_ok && (rdata0 > carry_q)) begin
      bigv = rdata0;
      bsel = 2'd1;
    end
    if (r_ok && (rdata1 > bigv)) begin
      bigv = rdata1;
      bsel = 2'd2;
    end
    npos = (bsel == 2'd2) ? rchild[AW-1:0] : lchild[AW-1:0];
    nl   = {1'b0, npos, 1'b1};
    nr   = {1'b0, npos, 1'b0} + PW'(2);

    state_d     = state_q;
    count_d     = count_q;
    hk_d        = hk_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    carry_d     = carry_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = carry_q;
    re          = 1'b0;
    raddr0      = parent;
    raddr1      = parent;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          last_d = in_beat_i.is_last;
          if (count_q < CapC) begin
            carry_d = in_beat_i.sample_value;
            pos_d   = AW'(count_q);
            count_d = count_q + CW'(1);
            state_d = S_UP;
          end else begin
            ovf_d = 1'b1;
            if (in_beat_i.is_last) begin
              hk_d    = count_q;
              idx_d   = '0;
              state_d = (count_q > CW'(1)) ? S_XRD : S_ORD;
            end
          end
        end
      end
      S_UP, S_UPC: begin
        if (state_q == S_UP && pos_q != '0) begin
          re      = 1'b1;
          state_d = S_UPC;
        end else if (state_q == S_UPC && carry_q > rdata0) begin
          we      = 1'b1;
          wdata   = rdata0;
          pos_d   = parent;
          state_d = S_UP;
        end else begin
          we = 1'b1;
          if (last_q) begin
            hk_d    = count_q;
            idx_d   = '0;
            state_d = (count_q > CW'(1)) ? S_XRD : S_ORD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_XRD: begin
        re      = 1'b1;
        raddr0  = '0;
        raddr1  = AW'(hk_q - CW'(1));
        state_d = S_XSWP;
      end
      S_XSWP: begin
        we      = 1'b1;
        waddr   = AW'(hk_q - CW'(1));
        wdata   = rdata0;
        carry_d = rdata1;
        hk_d    = hk_q - CW'(1);
        pos_d   = '0;
        re      = 1'b1;
        raddr0  = AW'(1);
        raddr1  = AW'(2);
        state_d = S_SD;
      end
      S_SD: begin
        we = 1'b1;
        if (bsel == 2'd0) begin
          if (hk_q > CW'(1)) begin
            state_d = S_XRD;
          end else begin
            idx_d   = '0;
            state_d = S_ORD;
          end
        end else begin
          wdata  = bigv;
          pos_d  = npos;
          re     = 1'b1;
          raddr0 = nl[AW-1:0];
          raddr1 = nr[AW-1:0];
        end
      end
      S_ORD: begin
        re      = 1'b1;
        raddr0  = idx_q;
        state_d = S_OLD;
      end
      S_OLD: begin
        if (out_free) begin
          out_d.sorted_value = rdata0;
          out_d.is_final     = is_final;
          out_d.overflowed   = ovf_q;
          out_valid_d        = 1'b1;
          if (is_final) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hk_q    <= hk_d;
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    carry_q <= carry_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("live count above capacity");

  a_write_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) < count_q))
    else $error("heap write outside live part");

  a_hole_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SD) |-> (CW'(pos_q) < hk_q))
    else $error("sift-down hole outside live part");

  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && count_q == CapC) |=> ovf_q || out_valid_o)
    else $error("dropped beat did not flag overflow");
`endif

endmodule
